[src/assert_macros.svh]
// Assertion helpers for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising edge outside reset.
`define SFD_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("sfd assertion failed");

// The expression must never be true at a rising edge outside reset.
`define SFD_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("sfd forbidden condition seen");

`endif

[src/sfd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package sfd_pkg;

	// Frame layout: nine 16-bit samples followed by a 32-bit timestamp.
	localparam int WindowBytes = 22;
	localparam int TimeBytes   = 4;
	localparam int NumSamples  = (WindowBytes - TimeBytes) / 2;
	localparam int FillW       = 5;
	localparam int ChanW       = 4;

	localparam logic [7:0] CharCr = 8'h0D;
	localparam logic [7:0] CharLf = 8'h0A;

	localparam logic [15:0] StatsPeriodReset = 16'd1000;
	localparam logic [15:0] CountMax         = 16'hFFFF;

	// Register map
	localparam logic [0:0] RegStatsPeriod = 1'b0;

	typedef logic [WindowBytes-1:0][7:0] window_t;

	// Everything needed to replay one terminator's results.
	typedef struct packed {
		logic [NumSamples-1:0][15:0] samples;
		logic [31:0]                 frame_time;
		logic                        frame_ok;
		logic                        stats_ok;
		logic [15:0]                 declined;
		logic [31:0]                 elapsed;
	} frame_rec_t;

endpackage

`default_nettype wire

[src/sfd_window.sv]
`timescale 1ns / 1ps
`default_nettype none

module sfd_window (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               take,
	input  wire logic [7:0]         data_byte,
	input  wire logic [15:0]        stats_period,
	output logic                    held_cr,
	output logic                    rec_load,
	output sfd_pkg::frame_rec_t     rec
);

	localparam logic [sfd_pkg::FillW-1:0] FillFull = sfd_pkg::FillW'(sfd_pkg::WindowBytes);

	sfd_pkg::window_t               win_q, win_a, win_b;
	logic [sfd_pkg::FillW-1:0]      fill_q, fill_a, fill_b;
	logic                           cr_q, cr_d;
	logic [15:0]                    term_q, decl_q, term_inc, decl_inc;
	logic [31:0]                    latest_q, report_q, latest_new, win_time;
	logic                           is_term, frame_ok, report_due;

	function automatic sfd_pkg::window_t push(input sfd_pkg::window_t w, input logic [7:0] b);
		sfd_pkg::window_t r;
		for (int i = 0; i < sfd_pkg::WindowBytes - 1; i++) begin
			r[i] = w[i+1];
		end
		r[sfd_pkg::WindowBytes-1] = b;
		return r;
	endfunction

	function automatic logic [sfd_pkg::FillW-1:0] fill_up(input logic [sfd_pkg::FillW-1:0] f);
		return (f < FillFull) ? f + 1'b1 : f;
	endfunction

	assign held_cr = cr_q;
	assign is_term = cr_q && (data_byte == sfd_pkg::CharLf);

	// A held CR that is not followed by LF enters the window first, then the new byte.
	always_comb begin
		win_a  = win_q;
		fill_a = fill_q;
		if (cr_q && !is_term) begin
			win_a  = push(win_q, sfd_pkg::CharCr);
			fill_a = fill_up(fill_q);
		end
		win_b  = win_a;
		fill_b = fill_a;
		cr_d   = 1'b0;
		if (!is_term) begin
			if (data_byte == sfd_pkg::CharCr) begin
				cr_d = 1'b1;
			end else begin
				win_b  = push(win_a, data_byte);
				fill_b = fill_up(fill_a);
			end
		end
	end

	// Decode of the window and the statistics update at a terminator.
	assign win_time   = {win_q[sfd_pkg::WindowBytes-1], win_q[sfd_pkg::WindowBytes-2],
			win_q[sfd_pkg::WindowBytes-3], win_q[sfd_pkg::WindowBytes-4]};
	assign frame_ok   = (fill_q >= FillFull);
	assign term_inc   = (term_q < sfd_pkg::CountMax) ? term_q + 16'd1 : term_q;
	assign decl_inc   = (!frame_ok && decl_q < sfd_pkg::CountMax) ? decl_q + 16'd1 : decl_q;
	assign latest_new = frame_ok ? win_time : latest_q;
	assign report_due = (term_inc >= stats_period);

	always_comb begin
		for (int i = 0; i < sfd_pkg::NumSamples; i++) begin
			rec.samples[i] = {win_q[2*i+1], win_q[2*i]};
		end
		rec.frame_time = latest_new;
		rec.frame_ok   = frame_ok;
		rec.stats_ok   = report_due;
		rec.declined   = report_due ? decl_inc : 16'd0;
		rec.elapsed    = report_due ? (latest_new - report_q) : 32'd0;
	end

	assign rec_load = take && is_term && (frame_ok || report_due);

	// State update on every accepted byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q    <= '0;
			fill_q   <= '0;
			cr_q     <= 1'b0;
			term_q   <= '0;
			decl_q   <= '0;
			latest_q <= '0;
			report_q <= '0;
		end else if (take) begin
			cr_q <= cr_d;
			if (is_term) begin
				fill_q   <= '0;
				latest_q <= latest_new;
				if (report_due) begin
					term_q   <= '0;
					decl_q   <= '0;
					report_q <= latest_new;
				end else begin
					term_q <= term_inc;
					decl_q <= decl_inc;
				end
			end else begin
				win_q  <= win_b;
				fill_q <= fill_b;
			end
		end
	end

endmodule

`default_nettype wire

[src/sfd_emitter.sv]
`timescale 1ns / 1ps
`default_nettype none

module sfd_emitter (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       rec_load,
	input  wire sfd_pkg::frame_rec_t        rec,
	output logic                            busy,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic [sfd_pkg::ChanW-1:0]       channel,
	output logic signed [15:0]              sample,
	output logic [31:0]                     frame_time,
	output logic                            frame_valid,
	output logic                            last,
	output logic                            stats_valid,
	output logic [15:0]                     declined_total,
	output logic [31:0]                     remote_elapsed
);

	localparam logic [sfd_pkg::ChanW-1:0] LastChan = sfd_pkg::ChanW'(sfd_pkg::NumSamples - 1);

	sfd_pkg::frame_rec_t            rec_q;
	logic                           busy_q;
	logic [sfd_pkg::ChanW-1:0]      idx_q;
	logic                           sent;

	assign busy      = busy_q;
	assign out_valid = busy_q;
	assign sent      = busy_q && !out_stall;

	// Result fields are selected from the held record by the channel counter.
	assign channel        = idx_q;
	assign sample         = rec_q.frame_ok ? $signed(rec_q.samples[idx_q]) : 16'sd0;
	assign frame_time     = rec_q.frame_time;
	assign frame_valid    = rec_q.frame_ok;
	assign last           = !rec_q.frame_ok || (idx_q == LastChan);
	assign stats_valid    = last && rec_q.stats_ok;
	assign declined_total = last ? rec_q.declined : 16'd0;
	assign remote_elapsed = last ? rec_q.elapsed : 32'd0;

	// Record capture; the input side never loads while results are pending.
	always_ff @(posedge clk) begin
		if (rec_load) begin
			rec_q <= rec;
		end
	end

	// Channel sequencing over the held record.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (rec_load) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (sent) begin
			if (last) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[src/sensor_frame_deframer_unit.sv]
// Deframer for CR LF terminated sensor frames. One serial byte is taken per
// clock cycle while in_valid is high and the input is not stalled. At a
// terminator preceded by at least 22 bytes, the last 22 bytes are decoded
// into nine signed little-endian samples and a 32-bit timestamp, held in a
// result register and sent as nine requests (channel 0 to 8, the ninth marked
// last); shorter frames are declined and counted. Every stats_period
// terminators the final request also reports the declined count and the
// elapsed remote time, and a declined frame then yields a single request of
// its own. Input bytes keep flowing while results drain; the input stalls
// only when a CR is held back and the previous terminator's requests are
// still being sent.
// stats_period sits at byte address 0 of the register port and resets to 1000.
`timescale 1ns / 1ps
`default_nettype none

module sensor_frame_deframer_unit (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// register port
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [2:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	// byte input
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [7:0]         data_byte,
	// results
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [3:0]              channel,
	output logic signed [15:0]      sample,
	output logic [31:0]             frame_time,
	output logic                    frame_valid,
	output logic                    last,
	output logic                    stats_valid,
	output logic [15:0]             declined_total,
	output logic [31:0]             remote_elapsed
);

	logic [15:0]            period_q;
	logic                   held_cr, busy, rec_load, take;
	sfd_pkg::frame_rec_t    rec;

	// Register port, always ready.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == sfd_pkg::RegStatsPeriod) ? {16'd0, period_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= sfd_pkg::StatsPeriodReset;
		end else if (psel && penable && pwrite && pready
				&& paddr[2] == sfd_pkg::RegStatsPeriod) begin
			period_q <= pwdata[15:0];
		end
	end

	// Only a byte after a held CR can complete a terminator, so hold off then.
	assign in_stall = held_cr && busy;
	assign take     = in_valid && !in_stall;

	sfd_window u_window (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (take),
		.data_byte    (data_byte),
		.stats_period (period_q),
		.held_cr      (held_cr),
		.rec_load     (rec_load),
		.rec          (rec)
	);

	sfd_emitter u_emitter (
		.clk            (clk),
		.arst_n         (arst_n),
		.rec_load       (rec_load),
		.rec            (rec),
		.busy           (busy),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.channel        (channel),
		.sample         (sample),
		.frame_time     (frame_time),
		.frame_valid    (frame_valid),
		.last           (last),
		.stats_valid    (stats_valid),
		.declined_total (declined_total),
		.remote_elapsed (remote_elapsed)
	);

endmodule

`default_nettype wire

[src/sfd_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sfd_checker (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               out_valid,
	input  wire logic               out_stall,
	input  wire logic [3:0]         channel,
	input  wire logic               frame_valid,
	input  wire logic               last,
	input  wire logic               stats_valid,
	input  wire logic [15:0]        declined_total,
	input  wire logic [31:0]        remote_elapsed
);

	// A stalled request keeps its channel.
	`SFD_ASSERT(a_stall_hold, clk, arst_n, out_valid && out_stall |=> out_valid && $stable(channel))

	// Frame requests follow each other channel by channel without gaps.
	`SFD_ASSERT(a_chan_step, clk, arst_n, out_valid && !out_stall && !last |=> out_valid && channel == $past(channel) + 4'd1)

	// Only the ninth sample of a frame ends it.
	`SFD_ASSERT(a_last_chan, clk, arst_n, out_valid && frame_valid |-> last == (channel == 4'd8))

	// A request without a sample exists only to carry a report.
	`SFD_NEVER(a_empty_req, clk, arst_n, out_valid && !frame_valid && !stats_valid)

	// Statistics fields stay clear away from the final request.
	`SFD_NEVER(a_stats_mid, clk, arst_n, out_valid && !last && (stats_valid || declined_total != 16'd0 || remote_elapsed != 32'd0))

endmodule

bind sensor_frame_deframer_unit sfd_checker u_sfd_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.channel        (channel),
	.frame_valid    (frame_valid),
	.last           (last),
	.stats_valid    (stats_valid),
	.declined_total (declined_total),
	.remote_elapsed (remote_elapsed)
);

`default_nettype wire

[bench/testbench.sv]
`timescale 1ns / 1ps

import sfd_pkg::*;

// One sample request as it leaves the block.
typedef struct packed {
	logic [ChanW-1:0] channel;
	logic [15:0]      sample;
	logic [31:0]      frame_time;
	logic             frame_valid;
	logic             last;
	logic             stats_valid;
	logic [15:0]      declined_total;
	logic [31:0]      remote_elapsed;
} sample_rec_t;

// Tracks the deframer's byte window and counters, and holds the sample requests
// that accepted bytes are due to produce.
class deframe_tracker;
	bit [7:0]    window [WindowBytes];
	bit          cr_held;
	int unsigned fill;
	int unsigned terms;
	int unsigned declined;
	bit [31:0]   latest_time;
	bit [31:0]   report_time;
	logic [15:0] period = StatsPeriodReset;
	sample_rec_t pending_samples [$];
	int          errors;
	int          bytes_seen;
	int          samples_seen;
	int          frames_decoded;
	int          frames_declined;
	int          reports;

	function void flag(string what);
		errors++;
		if (errors <= 10)
			$display("MISMATCH: %s", what);
	endfunction

	function string describe(sample_rec_t r);
		return $sformatf("ch=%0d sample=%0d time=%h ok=%b last=%b stats=%b declined=%0d elapsed=%h",
			r.channel, $signed(r.sample), r.frame_time, r.frame_valid, r.last,
			r.stats_valid, r.declined_total, r.remote_elapsed);
	endfunction

	function void shift_in(bit [7:0] b);
		for (int i = 0; i < WindowBytes - 1; i++)
			window[i] = window[i + 1];
		window[WindowBytes - 1] = b;
		if (fill < WindowBytes)
			fill++;
	endfunction

	// An accepted byte. A CR is held back for one byte so that a terminator
	// never reaches the window.
	function void take_byte(logic [7:0] b);
		bit          term;
		bit          decoded;
		sample_rec_t r;
		bytes_seen++;
		term = cr_held && b == CharLf;
		if (cr_held && !term)
			shift_in(CharCr);
		cr_held = !term && b == CharCr;
		if (!term && b != CharCr)
			shift_in(b);
		if (!term)
			return;

		// Terminator: decode a full window, otherwise decline the frame.
		decoded = fill >= WindowBytes;
		fill = 0;
		if (terms < CountMax)
			terms++;
		r = '0;
		if (decoded) begin
			latest_time = {window[21], window[20], window[19], window[18]};
			frames_decoded++;
			for (int i = 0; i < NumSamples; i++) begin
				r.channel     = ChanW'(i);
				r.sample      = {window[2 * i + 1], window[2 * i]};
				r.frame_time  = latest_time;
				r.frame_valid = 1'b1;
				r.last        = i == NumSamples - 1;
				if (i < NumSamples - 1)
					pending_samples.push_back(r);
			end
		end else begin
			frames_declined++;
			if (declined < CountMax)
				declined++;
			r.last       = 1'b1;
			r.frame_time = latest_time;
		end

		// Statistics ride on the final request of the terminator.
		if (terms >= period) begin
			r.stats_valid    = 1'b1;
			r.declined_total = declined[15:0];
			r.remote_elapsed = latest_time - report_time;
			report_time      = latest_time;
			declined         = 0;
			terms            = 0;
			reports++;
		end
		if (decoded || r.stats_valid)
			pending_samples.push_back(r);
	endfunction

	function void match_sample(sample_rec_t got);
		sample_rec_t want;
		samples_seen++;
		if (pending_samples.size() == 0) begin
			flag({"request with none expected: ", describe(got)});
			return;
		end
		want = pending_samples.pop_front();
		if (got.channel !== want.channel || got.sample !== want.sample ||
				got.frame_time !== want.frame_time || got.frame_valid !== want.frame_valid ||
				got.last !== want.last || got.stats_valid !== want.stats_valid ||
				got.declined_total !== want.declined_total ||
				got.remote_elapsed !== want.remote_elapsed)
			flag({"expected ", describe(want), " got ", describe(got)});
	endfunction
endclass

module testbench;
	localparam int         QuietLimit      = 2000;
	localparam int         SettleCycles    = 24;
	localparam int         PhaseBytes      = 16;
	localparam logic [2:0] StatsPeriodAddr = {RegStatsPeriod, 2'b00};

	logic        clk     = 1'b0;
	logic        arst_n  = 1'b0;
	logic        psel    = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite  = 1'b0;
	logic [2:0]  paddr   = '0;
	logic [31:0] pwdata  = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [3:0]  channel;
	logic signed [15:0] sample;
	logic [31:0] frame_time;
	logic        frame_valid;
	logic        last;
	logic        stats_valid;
	logic [15:0] declined_total;
	logic [31:0] remote_elapsed;

	bit             calm;
	logic [7:0]     last_sent;
	deframe_tracker sb = new;

	sensor_frame_deframer_unit dut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Gap before a request: mostly none or short, now and then long.
	function automatic int gap_cycles();
		int k;
		if (calm)
			return 0;
		k = $urandom_range(0, 99);
		if (k < 55)
			return 0;
		if (k < 92)
			return $urandom_range(1, 3);
		return $urandom_range(6, 40);
	endfunction

	// Random frame content, biased towards CR and LF but never a CR LF pair.
	function automatic logic [7:0] payload_byte();
		int         k;
		logic [7:0] b;
		k = $urandom_range(0, 99);
		if (k < 8)
			b = CharCr;
		else if (k < 13)
			b = CharLf;
		else
			b = 8'($urandom_range(0, 255));
		if (last_sent == CharCr && b == CharLf)
			b = 8'h3C;
		return b;
	endfunction

	task automatic send_byte(input logic [7:0] b);
		int g;
		g = gap_cycles();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		last_sent = b;
	endtask

	task automatic send_frame(input int len, input bit closed);
		repeat (len) send_byte(payload_byte());
		if (closed) begin
			send_byte(CharCr);
			send_byte(CharLf);
		end
	endtask

	// Hold the input until every expected request has come, then let the
	// block settle.
	task automatic drain_samples();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_samples.size() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic check_period_register(input logic [15:0] want);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= StatsPeriodAddr;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== {16'h0000, want})
			sb.flag($sformatf("stats_period reads %h, expected %h", prdata, want));
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_stats_period(input logic [15:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= StatsPeriodAddr;
		pwdata  <= {16'h0000, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		sb.period = value;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		check_period_register(value);
	endtask

	// Random back-pressure on the result side.
	initial begin : result_backpressure
		int g;
		forever begin
			g = gap_cycles();
			if (g > 0) begin
				out_stall <= 1'b1;
				repeat (g) @(posedge clk);
			end
			out_stall <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	// Both handshakes are sampled at the edge.
	always @(posedge clk) begin : monitor
		sample_rec_t got;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got.channel        = channel;
				got.sample         = sample;
				got.frame_time     = frame_time;
				got.frame_valid    = frame_valid;
				got.last           = last;
				got.stats_valid    = stats_valid;
				got.declined_total = declined_total;
				got.remote_elapsed = remote_elapsed;
				sb.match_sample(got);
			end
			if (in_valid && !in_stall)
				sb.take_byte(data_byte);
		end
	end

	// Ends the run when no request of any kind has been taken for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		wait (arst_n);
		while (quiet < QuietLimit) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
					(psel && penable && pready))
				quiet = 0;
			else
				quiet++;
		end
		$display("No request accepted for %0d cycles", QuietLimit);
		$display("sensor_frame_deframer_unit verification failed");
		$finish;
	end

	initial begin : stimulus
		logic [7:0]  probe [$];
		logic [15:0] periods [$];
		int          start_bytes;
		int          k;
		// Sample extremes, a CR followed by a data byte, a lone LF, a CR followed
		// by another CR, and an all-ones timestamp.
		probe = '{8'h00, 8'h80, 8'hFF, 8'h7F, 8'h00, 8'h00, 8'hFF, 8'hFF,
			8'h0D, 8'h55, 8'h0A, 8'h0A, 8'h34, 8'h12, 8'hC3, 8'hA5,
			8'h0D, 8'h0D, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
		periods = '{16'd0, 16'd65535, 16'd2, 16'd3, 16'd65535, 16'd1};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		check_period_register(StatsPeriodReset);

		// Directed: a full frame, then an empty one that is declined and still
		// carries a statistics report of its own.
		set_stats_period(16'd1);
		foreach (probe[i])
			send_byte(probe[i]);
		send_byte(CharCr);
		send_byte(CharLf);
		send_byte(CharCr);
		send_byte(CharLf);
		drain_samples();

		// Random phases over several statistics periods; the period drops after
		// the largest one may land below the running terminator count.
		foreach (periods[p]) begin
			calm = p == 2;
			set_stats_period(periods[p]);
			start_bytes = sb.bytes_seen;
			while (sb.bytes_seen - start_bytes < PhaseBytes) begin
				k = $urandom_range(0, 99);
				if (k < 60)
					send_frame(WindowBytes + $urandom_range(0, 3), 1'b1);
				else if (k < 85)
					send_frame($urandom_range(0, WindowBytes - 1), 1'b1);
				else
					send_frame($urandom_range(1, 6), 1'b0);
				if ($urandom_range(0, 7) == 0)
					drain_samples();
			end
			drain_samples();
		end

		if (sb.pending_samples.size() != 0)
			sb.flag($sformatf("%0d requests never arrived", sb.pending_samples.size()));
		$display("Sent %0d bytes: %0d frames decoded, %0d declined, %0d statistics reports.",
			sb.bytes_seen, sb.frames_decoded, sb.frames_declined, sb.reports);
		$display("Compared %0d sample requests over periods 1, 0, 65535, 2, 3, 65535, 1; %0d errors.",
			sb.samples_seen, sb.errors);
		if (sb.errors == 0)
			$display("sensor_frame_deframer_unit verification clean");
		else
			$display("sensor_frame_deframer_unit verification failed");
		$finish;
	end
endmodule
